// ===== rtl/wsp_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wsp_pkg
// Shared types and constants for the world-to-screen projection core.
// ----------------------------------------------------------------------------
package wsp_pkg;

   localparam int COORD_W = 32;
   localparam int SIZE_W  = 16;
   localparam int CSR_IDX_W = 3;
   localparam int CSR_DAT_W = 64;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_ROW_X_01 = 3'd0,
      CSR_ROW_X_23 = 3'd1,
      CSR_ROW_Y_01 = 3'd2,
      CSR_ROW_Y_23 = 3'd3,
      CSR_ROW_W_01 = 3'd4,
      CSR_ROW_W_23 = 3'd5,
      CSR_WIDTH    = 3'd6,
      CSR_HEIGHT   = 3'd7
   } csr_idx_type;

   typedef struct packed {
      logic signed [COORD_W-1:0] world_x;
      logic signed [COORD_W-1:0] world_y;
      logic signed [COORD_W-1:0] world_z;
   } req_type;

   typedef struct packed {
      logic signed [COORD_W-1:0] screen_x;
      logic signed [COORD_W-1:0] screen_y;
      logic                      behind_camera;
   } rsp_type;

endpackage

// ===== rtl/wsp_div_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wsp_div_cell
// One restoring-division cell: takes one dividend bit, emits one quotient bit.
// ----------------------------------------------------------------------------
module wsp_div_cell #(
   parameter int RW = 66,
   parameter int DW = 128,
   parameter int QW = 33
) (
   input  logic          clock,
   input  logic          enable,
   input  logic [RW-1:0] rem_i,
   input  logic [DW-1:0] num_i,
   input  logic [QW-1:0] quo_i,
   input  logic [RW-1:0] den_i,
   output logic [RW-1:0] rem_o,
   output logic [DW-1:0] num_o,
   output logic [QW-1:0] quo_o,
   output logic [RW-1:0] den_o
);
   logic [RW:0]   trial;
   logic [RW-1:0] rem_in;
   logic [QW-1:0] quo_in;
   logic          fit;
   logic [RW-1:0] rem_ff, den_ff;
   logic [DW-1:0] num_ff;
   logic [QW-1:0] quo_ff;

   always_comb begin
      trial  = {rem_i, num_i[DW-1]};
      fit    = trial >= {1'b0, den_i};
      rem_in = fit ? RW'(trial - {1'b0, den_i}) : trial[RW-1:0];
      // saturate the quotient once it exceeds its top code
      if (quo_i[QW-1]) begin
         quo_in = {1'b1, {(QW-1){1'b0}}};
      end else begin
         quo_in = {quo_i[QW-2:0], fit};
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         rem_ff <= rem_in;
         num_ff <= {num_i[DW-2:0], 1'b0};
         quo_ff <= quo_in;
         den_ff <= den_i;
      end
   end

   assign rem_o = rem_ff;
   assign num_o = num_ff;
   assign quo_o = quo_ff;
   assign den_o = den_ff;
endmodule

// ===== rtl/wsp_div_chain.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wsp_div_chain
// Row of division cells producing a saturated signed quotient.
// ----------------------------------------------------------------------------
module wsp_div_chain #(
   parameter int DW = 128,
   parameter int RW = 66,
   parameter int QW = 33
) (
   input  logic          clock,
   input  logic          enable,
   input  logic [DW-1:0] num_i,
   input  logic [RW-1:0] den_i,
   input  logic          neg_i,
   output logic [31:0]   quo_o
);
   logic [RW-1:0] rem [DW+1];
   logic [DW-1:0] num [DW+1];
   logic [QW-1:0] quo [DW+1];
   logic [RW-1:0] den [DW+1];
   logic [DW-1:0] neg_ff;
   logic [QW-1:0] q;

   assign rem[0] = '0;
   assign num[0] = num_i;
   assign quo[0] = '0;
   assign den[0] = den_i;

   for (genvar i = 0; i < DW; i++) begin : g_cell
      wsp_div_cell #(.RW(RW), .DW(DW), .QW(QW)) u_cell (
         .clock (clock), .enable(enable),
         .rem_i (rem[i]), .num_i(num[i]), .quo_i(quo[i]), .den_i(den[i]),
         .rem_o (rem[i+1]), .num_o(num[i+1]), .quo_o(quo[i+1]), .den_o(den[i+1])
      );
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         neg_ff <= {neg_ff[DW-2:0], neg_i};
      end
   end

   always_comb begin
      q = quo[DW];
      if (neg_ff[DW-1]) begin
         if (q > QW'(33'h080000000)) begin
            q = QW'(33'h080000000);
         end
         quo_o = 32'(-q);
      end else begin
         if (q > QW'(33'h07FFFFFFF)) begin
            q = QW'(33'h07FFFFFFF);
         end
         quo_o = q[31:0];
      end
   end
endmodule

// ===== rtl/world_to_screen_projection_core.sv =====
`timescale 1ns / 1ps
// Pipeline: 3 product/sum stages, one scaling stage, then 128 division cells
//   with one dividend bit per cell, then the output register.
// Throughput: one point per cycle; the whole pipe advances whenever the
//   output register is free or being drained.
// Reset: synchronous, active high; clears valids, matrix to 0, viewport 640x480.
// ----------------------------------------------------------------------------
// world_to_screen_projection_core
// Matrix transform of a world point followed by viewport mapping into pixels.
// ----------------------------------------------------------------------------
module world_to_screen_projection_core #(
   parameter int FRAC_BITS = 16
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  wsp_pkg::req_type          req_data,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output wsp_pkg::rsp_type          rsp_data,
   input  logic                      csr_valid,
   output logic                      csr_ready,
   input  logic [wsp_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [wsp_pkg::CSR_DAT_W-1:0] csr_data
);
   import wsp_pkg::*;

   localparam int DW    = 128;
   localparam int RW    = 66;
   localparam int QW    = 33;
   localparam int LAT   = 4 + DW;

   // configuration registers
   logic [63:0]       mat_ff [6];
   logic [SIZE_W-1:0] width_ff, height_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 6; i++) mat_ff[i] <= '0;
         width_ff  <= SIZE_W'(640);
         height_ff <= SIZE_W'(480);
      end else if (csr_valid && csr_ready) begin
         unique case (csr_idx_type'(csr_index))
            CSR_ROW_X_01: mat_ff[0] <= csr_data;
            CSR_ROW_X_23: mat_ff[1] <= csr_data;
            CSR_ROW_Y_01: mat_ff[2] <= csr_data;
            CSR_ROW_Y_23: mat_ff[3] <= csr_data;
            CSR_ROW_W_01: mat_ff[4] <= csr_data;
            CSR_ROW_W_23: mat_ff[5] <= csr_data;
            CSR_WIDTH:    width_ff  <= csr_data[SIZE_W-1:0];
            CSR_HEIGHT:   height_ff <= csr_data[SIZE_W-1:0];
            default: ;
         endcase
      end
   end

   // advance the whole pipe when the output slot is free or draining
   logic advance;
   logic [LAT-1:0] vld_ff;
   logic rsp_valid_ff;
   assign advance   = !rsp_valid_ff || !rsp_stall;
   assign req_stall = !advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         vld_ff       <= {vld_ff[LAT-2:0], req_valid};
         rsp_valid_ff <= vld_ff[LAT-1];
      end
   end

   // stage 1: nine exact products, floored to FRAC_BITS
   logic signed [63:0] prod_ff [9];
   logic signed [31:0] off_ff [3];
   logic signed [31:0] crd [3];
   assign crd[0] = req_data.world_x;
   assign crd[1] = req_data.world_y;
   assign crd[2] = req_data.world_z;

   always_ff @(posedge clock) begin
      if (advance) begin
         for (int r = 0; r < 3; r++) begin
            prod_ff[3*r+0] <= (crd[0] * $signed(mat_ff[2*r][31:0])) >>> FRAC_BITS;
            prod_ff[3*r+1] <= (crd[1] * $signed(mat_ff[2*r][63:32])) >>> FRAC_BITS;
            prod_ff[3*r+2] <= (crd[2] * $signed(mat_ff[2*r+1][31:0])) >>> FRAC_BITS;
            off_ff[r]      <= $signed(mat_ff[2*r+1][63:32]);
         end
      end
   end

   // stage 2: row sums
   logic signed [63:0] cx_ff, cy_ff, cw_ff;
   always_ff @(posedge clock) begin
      if (advance) begin
         cx_ff <= prod_ff[0] + prod_ff[1] + prod_ff[2] + 64'(off_ff[0]);
         cy_ff <= prod_ff[3] + prod_ff[4] + prod_ff[5] + 64'(off_ff[1]);
         cw_ff <= prod_ff[6] + prod_ff[7] + prod_ff[8] + 64'(off_ff[2]);
      end
   end

   // stage 3: numerators as sign and magnitude, behind flag
   logic [63:0] magx_ff, magy_ff;
   logic        negx_ff, negy_ff, behind_ff;
   logic [RW-1:0] den_ff;
   logic signed [63:0] nx, ny;
   always_comb begin
      nx = cx_ff + cw_ff;
      ny = cw_ff - cy_ff;
   end
   always_ff @(posedge clock) begin
      if (advance) begin
         negx_ff   <= nx[63];
         negy_ff   <= ny[63];
         magx_ff   <= nx[63] ? 64'(-nx) : nx;
         magy_ff   <= ny[63] ? 64'(-ny) : ny;
         behind_ff <= cw_ff <= 0;
         den_ff    <= {1'b0, cw_ff[63:0], 1'b0};
      end
   end

   // stage 4: scale by viewport size, then shift in the fraction
   logic [DW-1:0] numx_ff, numy_ff;
   logic [RW-1:0] den2_ff;
   logic          negx2_ff, negy2_ff, behind2_ff;
   logic [79:0]   px, py;
   always_comb begin
      px = magx_ff * width_ff;
      py = magy_ff * height_ff;
   end
   always_ff @(posedge clock) begin
      if (advance) begin
         numx_ff    <= DW'(px) << FRAC_BITS;
         numy_ff    <= DW'(py) << FRAC_BITS;
         den2_ff    <= den_ff;
         negx2_ff   <= negx_ff;
         negy2_ff   <= negy_ff;
         behind2_ff <= behind_ff;
      end
   end

   // behind flag rides alongside the division cells
   logic [DW-1:0] bh_ff;
   always_ff @(posedge clock) begin
      if (advance) begin
         bh_ff <= {bh_ff[DW-2:0], behind2_ff};
      end
   end

   logic [31:0] qx, qy;
   wsp_div_chain #(.DW(DW), .RW(RW), .QW(QW)) u_divx (
      .clock(clock), .enable(advance), .num_i(numx_ff), .den_i(den2_ff),
      .neg_i(negx2_ff), .quo_o(qx)
   );
   wsp_div_chain #(.DW(DW), .RW(RW), .QW(QW)) u_divy (
      .clock(clock), .enable(advance), .num_i(numy_ff), .den_i(den2_ff),
      .neg_i(negy2_ff), .quo_o(qy)
   );

   // output register: hold while stalled
   rsp_type rsp_ff;
   localparam logic [31:0] MINUS_ONE = 32'(-(64'sd1 <<< FRAC_BITS));
   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_ff.behind_camera <= bh_ff[DW-1];
         rsp_ff.screen_x      <= bh_ff[DW-1] ? MINUS_ONE : qx;
         rsp_ff.screen_y      <= bh_ff[DW-1] ? MINUS_ONE : qy;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("rsp payload moved under stall");
   a_stall: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid && rsp_stall)
      else $error("req stalled without output backpressure");
   a_behind: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.behind_camera |-> rsp_data.screen_x == MINUS_ONE)
      else $error("behind point not flagged -1");
endmodule
